// File: rtl/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
`timescale 1ns / 1ps

package bole_pkg;

    localparam int ELEM_W     = 32;
    localparam int POS_W      = 5;
    localparam int CFG_W      = 6;
    localparam int CNT_OUT_W  = 6;
    localparam int DUMP_LIMIT = 32;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef enum logic [2:0] {
        MODE_ADD_FRONT = 3'd0,
        MODE_ADD_END   = 3'd1,
        MODE_DELETE    = 3'd2,
        MODE_SWAP      = 3'd3,
        MODE_DUMP      = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_ERR   = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_PUT,
        ST_SW_RD1,
        ST_SW_RD2,
        ST_SW_WR1,
        ST_SW_WR2,
        ST_DUMP_RD,
        ST_DUMP_OUT,
        ST_RESULT
    } state_t;

endpackage

// File: rtl/bole_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        // read data holds while rd_en is low
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bounded_ordered_list_engine.sv
// Bounded ordered list engine: top level with sequencer, count and output register.
// Add at end writes the new element; add at front first shifts every element up one
//   place, delete shifts the elements above the position down, swap reads then writes both.
// One command at a time; the element RAM (one write, one read port) moves one element
//   per read and write state pair, which sets the cost of shifts and dumps.
// Reset (aresetn low, synchronous): list empty, capacity register 32, no result pending.
`timescale 1ns / 1ps

module bounded_ordered_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    // command words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] element_value, [36:32] first_position,
                                   // [41:37] second_position, [47:42] zero
    input  logic [2:0]  s_tuser,   // [2:0] mode

    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [5:0] count, [37:6] element_out, [39:38] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,   // last word caused by this command

    // capacity register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    import bole_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CFG_W-1:0]      cap_reg;
    logic [CW-1:0]         idx_reg, idx_next;      // destination / dump index
    mode_t                 op_reg, op_next;
    elem_t                 val_reg, val_next;
    logic [POS_W-1:0]      p1_reg, p1_next;
    logic [POS_W-1:0]      p2_reg, p2_next;
    status_t               status_reg, status_next;
    elem_t                 tmp_reg, tmp_next;      // first swap operand

    logic                  m_tvalid_reg, m_tvalid_next;
    status_t               m_status_reg;
    logic [CNT_OUT_W-1:0]  m_count_reg;
    elem_t                 m_elem_reg;
    logic                  m_last_reg;

    // output register load
    logic                  out_load;
    status_t               out_status;
    logic [CNT_OUT_W-1:0]  out_count;
    elem_t                 out_elem;
    logic                  out_last;

    // RAM port controls
    logic                  wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [ELEM_W-1:0]     wr_data, rd_data;

    // ------------------------------------------------------------------
    // Decode of the incoming command
    // ------------------------------------------------------------------
    mode_t                 in_mode;
    elem_t                 in_val;
    logic [POS_W-1:0]      in_p1, in_p2;
    logic                  in_full, in_p1_ok, in_p2_ok, in_p1_tail;
    logic                  slot_free;
    logic [CW-1:0]         src_idx, dump_n;
    logic                  dump_last, move_up_done;
    logic [CW-1:0]         new_count;

    assign in_mode = mode_t'(s_tuser);
    assign in_val  = s_tdata[31:0];
    assign in_p1   = s_tdata[36:32];
    assign in_p2   = s_tdata[41:37];

    // limit in force is min(capacity register, CAPACITY)
    assign in_full   = (count_reg == CW'(CAPACITY)) ||
                       (CMPW'(count_reg) >= CMPW'(cap_reg));
    assign in_p1_ok  = CMPW'(in_p1) < CMPW'(count_reg);
    assign in_p2_ok  = CMPW'(in_p2) < CMPW'(count_reg);
    // deleting the tail element needs no shift
    assign in_p1_tail = CMPW'(in_p1) == CMPW'(count_reg - CW'(1));

    assign slot_free = !m_tvalid_reg || m_tready;

    // shift source: one above for delete, one below for add at front
    assign src_idx = (op_reg == MODE_DELETE) ? idx_reg + CW'(1) : idx_reg - CW'(1);
    assign move_up_done = (idx_reg + CW'(1)) == (count_reg - CW'(1));

    // a dump emits at most DUMP_LIMIT words
    assign dump_n = (CMPW'(count_reg) > CMPW'(DUMP_LIMIT)) ? CW'(DUMP_LIMIT) : count_reg;
    assign dump_last = (idx_reg + CW'(1)) == dump_n;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_mode)
                        MODE_ADD_FRONT: begin
                            if (in_full) begin
                                state_next = ST_RESULT;
                            end else if (count_reg == '0) begin
                                state_next = ST_PUT;
                            end else begin
                                state_next = ST_MOVE_RD;
                            end
                        end
                        MODE_ADD_END: begin
                            state_next = in_full ? ST_RESULT : ST_PUT;
                        end
                        MODE_DELETE: begin
                            if (!in_p1_ok || in_p1_tail) begin
                                state_next = ST_RESULT;
                            end else begin
                                state_next = ST_MOVE_RD;
                            end
                        end
                        MODE_SWAP: begin
                            if (in_p1 == in_p2 || !in_p1_ok || !in_p2_ok) begin
                                state_next = ST_RESULT;
                            end else begin
                                state_next = ST_SW_RD1;
                            end
                        end
                        MODE_DUMP: begin
                            state_next = (count_reg == '0) ? ST_RESULT : ST_DUMP_RD;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_MOVE_RD: state_next = ST_MOVE_WR;
            ST_MOVE_WR: begin
                if (op_reg == MODE_DELETE) begin
                    state_next = move_up_done ? ST_RESULT : ST_MOVE_RD;
                end else begin
                    state_next = (idx_reg == CW'(1)) ? ST_PUT : ST_MOVE_RD;
                end
            end
            ST_PUT:     state_next = ST_RESULT;
            ST_SW_RD1:  state_next = ST_SW_RD2;
            ST_SW_RD2:  state_next = ST_SW_WR1;
            ST_SW_WR1:  state_next = ST_SW_WR2;
            ST_SW_WR2:  state_next = ST_RESULT;
            ST_DUMP_RD: state_next = ST_DUMP_OUT;
            ST_DUMP_OUT: begin
                if (slot_free) begin
                    state_next = dump_last ? ST_IDLE : ST_DUMP_RD;
                end
            end
            ST_RESULT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath
    // ------------------------------------------------------------------
    always_comb begin
        rd_en       = 1'b0;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = rd_data;
        out_load    = 1'b0;
        out_status  = status_reg;
        out_count   = CNT_OUT_W'(count_reg);
        out_elem    = '0;
        out_last    = 1'b1;
        count_next  = count_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        status_next = status_reg;
        tmp_next    = tmp_reg;
        new_count   = count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next     = in_mode;
                    val_next    = in_val;
                    p1_next     = in_p1;
                    p2_next     = in_p2;
                    status_next = STAT_OK;
                    unique case (in_mode)
                        MODE_ADD_FRONT: begin
                            if (in_full) status_next = STAT_ERR;
                            idx_next = count_reg;
                        end
                        MODE_ADD_END: begin
                            if (in_full) status_next = STAT_ERR;
                        end
                        MODE_DELETE: begin
                            if (!in_p1_ok) status_next = STAT_ERR;
                            idx_next = CW'(in_p1);
                        end
                        MODE_SWAP: begin
                            if (in_p1 == in_p2 || !in_p1_ok || !in_p2_ok) begin
                                status_next = STAT_ERR;
                            end
                        end
                        MODE_DUMP: begin
                            if (count_reg == '0) status_next = STAT_EMPTY;
                            idx_next = '0;
                        end
                        default: begin
                            status_next = STAT_ERR;
                        end
                    endcase
                end
            end
            ST_MOVE_RD: begin
                rd_en   = 1'b1;
                rd_addr = src_idx[AW-1:0];
            end
            ST_MOVE_WR: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                wr_data = rd_data;
                idx_next = (op_reg == MODE_DELETE) ? idx_reg + CW'(1) : idx_reg - CW'(1);
            end
            ST_PUT: begin
                wr_en   = 1'b1;
                wr_addr = (op_reg == MODE_ADD_END) ? count_reg[AW-1:0] : '0;
                wr_data = val_reg;
            end
            ST_SW_RD1: begin
                rd_en   = 1'b1;
                rd_addr = AW'(p1_reg);
            end
            ST_SW_RD2: begin
                tmp_next = rd_data;
                rd_en    = 1'b1;
                rd_addr  = AW'(p2_reg);
            end
            ST_SW_WR1: begin
                wr_en   = 1'b1;
                wr_addr = AW'(p1_reg);
                wr_data = rd_data;
            end
            ST_SW_WR2: begin
                wr_en   = 1'b1;
                wr_addr = AW'(p2_reg);
                wr_data = tmp_reg;
            end
            ST_DUMP_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[AW-1:0];
            end
            ST_DUMP_OUT: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_status = STAT_OK;
                    out_elem   = rd_data;
                    out_last   = dump_last;
                    idx_next   = idx_reg + CW'(1);
                end
            end
            ST_RESULT: begin
                if (status_reg == STAT_OK) begin
                    if (op_reg == MODE_ADD_FRONT || op_reg == MODE_ADD_END) begin
                        new_count = count_reg + CW'(1);
                    end else if (op_reg == MODE_DELETE) begin
                        new_count = count_reg - CW'(1);
                    end
                end
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_count  = CNT_OUT_W'(new_count);
                    count_next = new_count;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tvalid_reg && !m_tready);

    // ------------------------------------------------------------------
    // Sequential logic
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cap_reg      <= CFG_W'(32);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        val_reg    <= val_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        status_reg <= status_next;
        tmp_reg    <= tmp_next;
        if (out_load) begin
            m_status_reg <= out_status;
            m_count_reg  <= out_count;
            m_elem_reg   <= out_elem;
            m_last_reg   <= out_last;
        end
    end

    // ------------------------------------------------------------------
    // Element store
    // ------------------------------------------------------------------
    bole_ram #(
        .WIDTH(ELEM_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, m_elem_reg, m_count_reg};
    assign m_tuser   = m_status_reg;
    assign m_tlast   = m_last_reg;

`ifndef SYNTH
    // count never passes the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(count_reg) <= CMPW'(CAPACITY))
        else $error("list count beyond capacity");

    // a pending result word is never overwritten
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid_reg && !m_tready && out_load))
        else $error("result word overwritten while stalled");

    // dump reads stay inside the held elements
    a_dump_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP_RD) |-> (idx_reg < count_reg))
        else $error("dump read past count");

    // a swap of a position with itself is refused without touching the store
    a_swap_same: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && in_mode == MODE_SWAP && in_p1 == in_p2)
        |=> (state_reg == ST_RESULT && status_reg == STAT_ERR))
        else $error("equal swap positions not refused");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the bounded ordered list engine.
`timescale 1ns / 1ps

module tb;

    import bole_pkg::*;

    // Modes above MODE_DUMP are unused and must come back as a single error word
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    localparam int         LIST_DEPTH       = 32;   // CAPACITY of the instance
    localparam int         DRAIN_CYCLES     = 80;   // margin beyond the longest shift

    // Predicts the list contents and every result word; checks words in order.
    class list_scoreboard;
        typedef struct {
            status_t     status;
            logic [5:0]  count;
            elem_t       element;
            logic        last;
        } word_t;

        elem_t       slots[LIST_DEPTH];
        int unsigned held;
        logic [5:0]  cap_reg;
        word_t       pending_q[$];
        int unsigned errors;
        int unsigned commands_seen;
        int unsigned words_seen;

        function new();
            held          = 0;
            cap_reg       = 6'd32;
            errors        = 0;
            commands_seen = 0;
            words_seen    = 0;
        endfunction

        function void set_capacity(logic [5:0] v);
            cap_reg = v;
        endfunction

        function void push(status_t s, elem_t e, logic last);
            word_t w;
            w.status  = s;
            w.count   = held[5:0];
            w.element = e;
            w.last    = last;
            pending_q.push_back(w);
        endfunction

        // Applies one accepted command to the model and queues its result words
        function void note_command(logic [2:0] mode, elem_t value,
                                   logic [4:0] p1, logic [4:0] p2);
            int unsigned lim;
            elem_t       tmp;
            commands_seen++;
            lim = (cap_reg < LIST_DEPTH) ? cap_reg : LIST_DEPTH;
            case (mode)
                MODE_ADD_FRONT, MODE_ADD_END: begin
                    if (held >= lim) begin
                        push(STAT_ERR, '0, 1'b1);
                    end else begin
                        if (mode == MODE_ADD_FRONT) begin
                            for (int i = held; i > 0; i--) slots[i] = slots[i-1];
                            slots[0] = value;
                        end else begin
                            slots[held] = value;
                        end
                        held++;
                        push(STAT_OK, '0, 1'b1);
                    end
                end
                MODE_DELETE: begin
                    if (p1 >= held) begin
                        push(STAT_ERR, '0, 1'b1);
                    end else begin
                        for (int i = p1; i + 1 < held; i++) slots[i] = slots[i+1];
                        held--;
                        push(STAT_OK, '0, 1'b1);
                    end
                end
                MODE_SWAP: begin
                    // a position equal to the count is out of range, too
                    if (p1 == p2 || p1 >= held || p2 >= held) begin
                        push(STAT_ERR, '0, 1'b1);
                    end else begin
                        tmp       = slots[p1];
                        slots[p1] = slots[p2];
                        slots[p2] = tmp;
                        push(STAT_OK, '0, 1'b1);
                    end
                end
                MODE_DUMP: begin
                    if (held == 0) begin
                        push(STAT_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < held; i++)
                            push(STAT_OK, slots[i], (i + 1 == held));
                    end
                end
                default: push(STAT_ERR, '0, 1'b1);
            endcase
        endfunction

        function void check_result(status_t s, logic [5:0] c, elem_t e, logic last);
            word_t w;
            words_seen++;
            if (pending_q.size() == 0) begin
                $error("result word with nothing expected: status %0d count %0d", s, c);
                errors++;
                return;
            end
            w = pending_q.pop_front();
            if (s !== w.status) begin
                $error("status: expected %0d, got %0d", w.status, s);
                errors++;
            end
            if (c !== w.count) begin
                $error("count: expected %0d, got %0d", w.count, c);
                errors++;
            end
            if (e !== w.element) begin
                $error("element_out: expected %0d, got %0d", w.element, e);
                errors++;
            end
            if (last !== w.last) begin
                $error("last: expected %0d, got %0d", w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // [31:0] element_value, [36:32] first_position,
                             // [41:37] second_position, [47:42] zero
    logic [2:0]  s_tuser;    // [2:0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [5:0] count, [37:6] element_out, [39:38] zero
    logic [1:0]  m_tuser;    // [1:0] status
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;

    list_scoreboard sb;
    bit             rush;            // both sides run without gaps
    int unsigned    rx_hold_cycles;  // one-shot long stall request for the receiver
    int unsigned    cap_writes;

    bounded_ordered_list_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Offers one command word after a random gap; returns once it is taken.
    // tvalid is only lowered when a gap follows, so a back-to-back word never
    // sees a low and a high assignment in the same step.
    task automatic send_cmd(input logic [2:0] mode, input elem_t value,
                            input logic [4:0] p1, input logic [4:0] p2);
        int unsigned gap;
        gap = rush ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, p2, p1, value};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(mode, value, p1, p2);
    endtask

    // Sender pause: stop offering and wait until every expected word is back.
    // Always followed by something that advances time.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    // Capacity only changes while the engine is idle
    task automatic write_capacity(input logic [5:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_capacity(v);
        cap_writes++;
    endtask

    // Mostly positions inside the list, sometimes anywhere in the field
    function automatic logic [4:0] pick_pos();
        if (sb.held > 0 && $urandom_range(0, 9) < 8)
            return 5'($urandom_range(0, sb.held - 1));
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic random_cmd(input int unsigned add_pct);
        logic [2:0]  mode;
        elem_t       value;
        logic [4:0]  p1;
        logic [4:0]  p2;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
            mode = $urandom_range(0, 1) ? MODE_ADD_END : MODE_ADD_FRONT;
        end else begin
            roll = $urandom_range(0, 19);
            if (roll < 8)       mode = MODE_DELETE;
            else if (roll < 16) mode = MODE_SWAP;
            else if (roll < 19) mode = MODE_DUMP;
            else                mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        end
        case ($urandom_range(0, 7))
            0:       value = 32'sh7FFF_FFFF;
            1:       value = 32'sh8000_0000;
            default: value = $urandom();
        endcase
        p1 = pick_pos();
        p2 = pick_pos();
        // keep equal swap positions rare but present
        if (mode == MODE_SWAP && p1 == p2 && sb.held > 1 && $urandom_range(0, 3) != 0)
            p2 = 5'((p1 + 1) % sb.held);
        send_cmd(mode, value, p1, p2);
    endtask

    // Result side: random stalls, an occasional long hold-off, checks each word
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = rush ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(status_t'(m_tuser), m_tdata[5:0], m_tdata[37:6], m_tlast);
        end
    end

    // Main sequence
    initial begin
        logic [5:0] caps[8];
        int unsigned add_pct[8];
        sb             = new();
        rush           = 1'b0;
        rx_hold_cycles = 0;
        cap_writes     = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list, unused modes, field extremes, range checks
        send_cmd(MODE_DUMP,      '0, 5'd0,  5'd0);     // empty dump
        send_cmd(MODE_DELETE,    '0, 5'd0,  5'd0);     // delete on empty
        send_cmd(MODE_SWAP,      '0, 5'd0,  5'd1);     // swap on empty
        send_cmd(MODE_SPARE_FIRST, 32'sh7FFF_FFFF, 5'd31, 5'd31);
        send_cmd(3'd6,           32'sh8000_0000, 5'd0, 5'd31);
        send_cmd(MODE_SPARE_LAST, -32'sd1, 5'd31, 5'd0);
        send_cmd(MODE_ADD_FRONT, 32'sh7FFF_FFFF, 5'd31, 5'd31);
        send_cmd(MODE_ADD_END,   32'sh8000_0000, 5'd0,  5'd0);
        send_cmd(MODE_ADD_FRONT, -32'sd1, 5'd0, 5'd0);
        send_cmd(MODE_ADD_END,   32'sd0,  5'd0, 5'd0);
        send_cmd(MODE_DUMP,      '0, 5'd0,  5'd0);
        send_cmd(MODE_SWAP,      '0, 5'd0,  5'd1);     // ok
        send_cmd(MODE_SWAP,      '0, 5'd1,  5'd1);     // equal positions
        send_cmd(MODE_SWAP,      '0, 5'd0,  5'd4);     // second position equals count
        send_cmd(MODE_SWAP,      '0, 5'd4,  5'd0);     // first position equals count
        send_cmd(MODE_SWAP,      '0, 5'd31, 5'd2);
        send_cmd(MODE_DELETE,    '0, 5'd3,  5'd0);     // last element
        send_cmd(MODE_DELETE,    '0, 5'd0,  5'd0);     // front
        send_cmd(MODE_DELETE,    '0, 5'd2,  5'd0);     // equals count
        send_cmd(MODE_DELETE,    '0, 5'd31, 5'd31);
        send_cmd(MODE_DUMP,      '0, 5'd0,  5'd0);

        // Fill to the full depth while the receiver holds off for a long
        // stretch, so the engine backs up and stalls the command side
        write_capacity(6'd63);
        rx_hold_cycles = 300;
        while (sb.held < LIST_DEPTH)
            send_cmd($urandom_range(0, 1) ? MODE_ADD_END : MODE_ADD_FRONT,
                     $urandom(), 5'($urandom()), 5'($urandom()));
        send_cmd(MODE_ADD_END,   $urandom(), 5'd0, 5'd0);  // full
        send_cmd(MODE_DUMP,      '0, 5'd0,  5'd0);         // 32 words
        send_cmd(MODE_SWAP,      '0, 5'd31, 5'd30);
        send_cmd(MODE_SWAP,      '0, 5'd0,  5'd31);
        send_cmd(MODE_DELETE,    '0, 5'd31, 5'd0);
        repeat (10) random_cmd(20);

        // Random phases; capacity 0 comes right after a nearly full list, so
        // adds are refused with elements still held
        caps    = '{6'd0, 6'd5, 6'd32, 6'd1, 6'd63, 6'd2, 6'd0, 6'd32};
        add_pct = '{40, 30, 70, 50, 60, 40, 30, 45};
        caps[6] = 6'($urandom_range(0, 63));
        for (int ph = 0; ph < 8; ph++) begin
            write_capacity(caps[ph]);
            rush = (ph == 3);   // one stretch with no idling at all
            repeat (12) random_cmd(add_pct[ph]);
            rush = 1'b0;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d commands, %0d result words, %0d capacity writes",
                 sb.commands_seen, sb.words_seen, cap_writes);
        $display("list filled to %0d entries, long receiver hold-off and one gapless stretch",
                 LIST_DEPTH);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #(20_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/bole_pkg.sv
rtl/bole_ram.sv
rtl/bounded_ordered_list_engine.sv
tb/tb.sv
